[hdl/fts_pkg.sv]
// Shared types, constants and helper functions of the fan tach speed supervisor.
// Used by every module of the block; depends on nothing.
package fts_pkg;

  localparam int DIVIDEND_W = 47;
  localparam int DIVISOR_W  = 32;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;

  localparam logic [6:0]  MIN_RUN_PCT    = 7'd25;
  localparam logic [6:0]  MAX_PCT        = 7'd100;
  localparam logic [31:0] ASSIST_MS      = 32'd5000;
  localparam logic [31:0] SAMPLE_MS      = 32'd1000;
  localparam logic [31:0] GRACE_MS       = 32'd3000;
  localparam logic [15:0] MIN_OK_RPM     = 16'd300;
  localparam logic [15:0] RESET_MAX_RPM  = 16'd6000;
  localparam logic [16:0] RESET_MIN_EDGE = 17'd5000;
  localparam logic [14:0] RPM_SCALE      = 15'd30000;
  localparam logic [24:0] GAP_SCALE      = 25'd30000000;
  localparam logic [7:0]  PWM_TOP        = 8'd255;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [31:0] now_us;
    logic [7:0]  speed_percent;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pwm_counts;
    logic        power_on;
    logic [6:0]  applied_percent;
    logic [15:0] speed_rpm;
    logic        stall_failed;
    logic        edge_accepted;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic use_meas;
    logic div_start;
    logic cfg_wr;
    logic gap_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

  // 255 - (d * 255 + 50) / 100, the divide by 100 done as a reciprocal multiply.
  function automatic logic [7:0] pwm_from_duty(input logic [6:0] duty);
    logic [14:0] scaled;
    logic [27:0] prod;
    scaled = 15'(({8'd0, duty} << 8) - {8'd0, duty}) + 15'd50;
    prod   = {13'd0, scaled} * 28'd5243;
    return PWM_TOP - prod[26:19];
  endfunction

endpackage

[hdl/fts_div.sv]
// Restoring divider that produces one quotient bit per cycle.
// Depends on fts_pkg for the operand widths.
module fts_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fts_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [fts_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [fts_pkg::DIVIDEND_W-1:0] quotient
);
  import fts_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
        rem_r  <= '0;
        div_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= fits ? DIVISOR_W'(trial - {1'b0, div_r}) : DIVISOR_W'(trial);
        quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/fts_dpath.sv]
// Datapath: supervisor state, event arithmetic, rpm and debounce division, result register.
// Depends on fts_pkg and instantiates fts_div.
module fts_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  fts_pkg::cmd_t      cmd,
  output fts_pkg::sts_t      sts,
  input  fts_pkg::in_item_t  in_item,
  input  logic [15:0]        cfg_data,
  output fts_pkg::out_item_t out_item
);
  import fts_pkg::*;

  in_item_t  item_r;
  out_item_t out_r;

  logic        power_r, power_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic [15:0] rpm_r, rpm_nxt;
  logic [31:0] pulse_r, pulse_nxt;
  logic [31:0] last_edge_r, last_edge_nxt;
  logic [31:0] win_start_r, win_start_nxt;
  logic        win_valid_r, win_valid_nxt;
  logic [31:0] assist_r, assist_nxt;
  logic [31:0] stall_since_r, stall_since_nxt;
  logic        stall_valid_r, stall_valid_nxt;
  logic        failed_r, failed_nxt;
  logic        edge_acc;
  logic [15:0] max_rpm_r;
  logic [16:0] min_edge_r;

  logic [31:0] ws_eff, elapsed, assist_gap;
  logic        running, assist_on;
  logic [6:0]  pct_c;
  logic [15:0] meas, rpm_tmp, lim;
  logic [17:0] filt_sum;

  logic                  div_go;
  logic [DIVIDEND_W-1:0] div_a;
  logic [DIVISOR_W-1:0]  div_b;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quo;

  assign ws_eff     = win_valid_r ? win_start_r : item_r.now_ms;
  assign elapsed    = item_r.now_ms - ws_eff;
  assign running    = power_r && (duty_r != '0);
  assign assist_gap = item_r.now_ms - assist_r;
  assign assist_on  = assist_gap[31];
  assign pct_c      = (item_r.speed_percent > {1'b0, MAX_PCT}) ? MAX_PCT
                                                               : item_r.speed_percent[6:0];
  assign meas       = quo[15:0];
  assign filt_sum   = 18'({rpm_r, 1'b0}) + 18'(rpm_r) + 18'(meas) + 18'd2;
  assign lim        = (cfg_data < MIN_OK_RPM) ? MIN_OK_RPM : cfg_data;

  assign sts.need_div = (item_r.op == OP_UPDATE) && running && (elapsed >= SAMPLE_MS);
  assign sts.div_done = div_done;

  assign div_go = cmd.div_start || cmd.cfg_wr;
  always_comb begin
    if (cmd.cfg_wr) begin
      div_a = DIVIDEND_W'(GAP_SCALE);
      div_b = DIVISOR_W'(lim);
    end else begin
      div_a = DIVIDEND_W'(pulse_r) * DIVIDEND_W'(RPM_SCALE);
      div_b = elapsed;
    end
  end

  fts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    power_nxt       = power_r;
    duty_nxt        = duty_r;
    rpm_nxt         = rpm_r;
    pulse_nxt       = pulse_r;
    last_edge_nxt   = last_edge_r;
    win_start_nxt   = win_start_r;
    win_valid_nxt   = win_valid_r;
    assist_nxt      = assist_r;
    stall_since_nxt = stall_since_r;
    stall_valid_nxt = stall_valid_r;
    failed_nxt      = failed_r;
    edge_acc        = 1'b0;
    rpm_tmp         = rpm_r;
    case (item_r.op)
      OP_UPDATE: begin
        if (!win_valid_r) begin
          pulse_nxt     = '0;
          last_edge_nxt = item_r.now_us;
          win_start_nxt = item_r.now_ms;
          win_valid_nxt = 1'b1;
        end
        if (!running) begin
          rpm_nxt         = '0;
          stall_valid_nxt = 1'b0;
          if (elapsed >= SAMPLE_MS) begin
            pulse_nxt     = '0;
            last_edge_nxt = item_r.now_us;
            win_start_nxt = item_r.now_ms;
            win_valid_nxt = 1'b1;
          end
        end else begin
          if (cmd.use_meas) begin
            pulse_nxt     = '0;
            win_start_nxt = item_r.now_ms;
            if (quo <= DIVIDEND_W'(max_rpm_r)) begin
              rpm_tmp = ((rpm_r == '0) || (meas == '0)) ? meas : filt_sum[17:2];
            end
          end
          rpm_nxt = rpm_tmp;
          if (assist_on || (rpm_tmp >= MIN_OK_RPM)) begin
            stall_valid_nxt = 1'b0;
          end else if (!stall_valid_r) begin
            stall_since_nxt = item_r.now_ms;
            stall_valid_nxt = 1'b1;
          end else if ((item_r.now_ms - stall_since_r) >= GRACE_MS) begin
            failed_nxt = 1'b1;
          end
        end
      end
      OP_EDGE: begin
        if ((item_r.now_us - last_edge_r) >= 32'(min_edge_r)) begin
          pulse_nxt     = pulse_r + 32'd1;
          last_edge_nxt = item_r.now_us;
          edge_acc      = 1'b1;
        end
      end
      OP_SET: begin
        if (pct_c == '0) begin
          assist_nxt      = '0;
          stall_valid_nxt = 1'b0;
          failed_nxt      = 1'b0;
          rpm_nxt         = '0;
          duty_nxt        = '0;
          power_nxt       = 1'b0;
          pulse_nxt       = '0;
          last_edge_nxt   = item_r.now_us;
          win_start_nxt   = item_r.now_ms;
          win_valid_nxt   = 1'b1;
        end else if (!power_r) begin
          assist_nxt      = item_r.now_ms + ASSIST_MS;
          stall_valid_nxt = 1'b0;
          failed_nxt      = 1'b0;
          pulse_nxt       = '0;
          last_edge_nxt   = item_r.now_us;
          win_start_nxt   = item_r.now_ms;
          win_valid_nxt   = 1'b1;
          duty_nxt        = MIN_RUN_PCT;
          power_nxt       = 1'b1;
        end else if (assist_on) begin
          duty_nxt = MIN_RUN_PCT;
        end else begin
          duty_nxt = (pct_c < MIN_RUN_PCT) ? MIN_RUN_PCT : pct_c;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_r       <= 1'b0;
      duty_r        <= '0;
      rpm_r         <= '0;
      pulse_r       <= '0;
      last_edge_r   <= '0;
      win_start_r   <= '0;
      win_valid_r   <= 1'b0;
      assist_r      <= '0;
      stall_since_r <= '0;
      stall_valid_r <= 1'b0;
      failed_r      <= 1'b0;
      max_rpm_r     <= RESET_MAX_RPM;
      min_edge_r    <= RESET_MIN_EDGE;
    end else begin
      if (cmd.apply) begin
        power_r       <= power_nxt;
        duty_r        <= duty_nxt;
        rpm_r         <= rpm_nxt;
        pulse_r       <= pulse_nxt;
        last_edge_r   <= last_edge_nxt;
        win_start_r   <= win_start_nxt;
        win_valid_r   <= win_valid_nxt;
        assist_r      <= assist_nxt;
        stall_since_r <= stall_since_nxt;
        stall_valid_r <= stall_valid_nxt;
        failed_r      <= failed_nxt;
      end
      if (cmd.cfg_wr) begin
        max_rpm_r <= cfg_data;
      end
      if (cmd.gap_load) begin
        min_edge_r <= quo[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.apply) begin
      out_r.pwm_counts      <= pwm_from_duty(duty_nxt);
      out_r.power_on        <= power_nxt;
      out_r.applied_percent <= duty_nxt;
      out_r.speed_rpm       <= rpm_nxt;
      out_r.stall_failed    <= failed_nxt;
      out_r.edge_accepted   <= edge_acc;
    end
  end

  assign out_item = out_r;

endmodule

[hdl/fts_ctrl.sv]
// Controller state machine: handshakes, sequencing of event execution and division.
// Depends on fts_pkg for the command and status types.
module fts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output fts_pkg::cmd_t cmd,
  input  fts_pkg::sts_t sts
);
  import fts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_GAP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.cfg_wr    = cfg_valid && cfg_ready;
    cmd.load      = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.cfg_wr) begin
          state_nxt = S_GAP;
        end else if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.apply    = 1'b1;
          cmd.use_meas = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_GAP: begin
        if (sts.div_done) begin
          cmd.gap_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/fan_tach_speed_supervisor_core.sv]
// Top level of the fan tach speed supervisor: controller plus datapath.
// Depends on fts_pkg, fts_ctrl, fts_dpath and fts_div.
//
//   Channel  Handshake              Payload
//   in_      in_valid / in_ready    in_item  (op, now_ms, now_us, speed_percent)
//   out_     out_valid / out_ready  out_item (pwm, power, duty, rpm, failed, edge)
//   cfg_     cfg_valid / cfg_ready  cfg_data (max_valid_rpm)
//
// Tach edges, speed requests and updates without a full window pass through the execute state only.
// An update that closes an rpm window also waits in the divide state for the bit-serial divider.
// A configuration write holds off items while the debounce gap is divided.
// The result register frees the input side once the last result is being taken.
// Reset is synchronous and needs no clearing pass.
module fan_tach_speed_supervisor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fts_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import fts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  fts_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

endmodule

[tb/fts_status_checker.sv]
// Checker for the fan tach speed supervisor: watches the item, result and register channels,
// predicts every status item from its own copy of the supervisor state and compares it.
// Depends on fts_pkg for the item types and constants.
module fts_status_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  fts_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  fts_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [15:0]        cfg_data,
  output int                 error_count,
  output int                 awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fts_pkg::*;

  logic [15:0] max_rpm;
  logic [16:0] edge_gap_us;
  logic        powered;
  logic [6:0]  duty_now;
  logic [6:0]  duty_req;
  logic [15:0] rpm_avg;
  logic [31:0] pulses;
  logic [31:0] last_edge;
  logic [31:0] win_start;
  logic        win_ok;
  logic [31:0] assist_end;
  logic [31:0] stall_start;
  logic        stall_ok;
  logic        failed;

  out_item_t status_q[$];
  int        errs = 0;
  int        outstanding = 0;

  assign error_count   = errs;
  assign awaited_count = outstanding;

  function automatic logic [16:0] gap_for(input logic [15:0] rpm);
    int unsigned lim;
    lim = (rpm < MIN_OK_RPM) ? 32'(MIN_OK_RPM) : 32'(rpm);
    return 17'(60000000 / (lim * 2));
  endfunction

  function automatic logic assist_on(input logic [31:0] ms);
    logic [31:0] d;
    d = ms - assist_end;
    return d[31];
  endfunction

  task automatic restart_win(input logic [31:0] ms, input logic [31:0] us);
    pulses    = '0;
    last_edge = us;
    win_start = ms;
    win_ok    = 1'b1;
  endtask

  task automatic apply_event(input in_item_t it, output out_item_t res);
    logic [31:0] ms;
    logic [31:0] us;
    logic [31:0] el;
    logic [63:0] meas;
    logic [7:0]  pct;
    logic        hit;
    ms  = it.now_ms;
    us  = it.now_us;
    hit = 1'b0;
    case (it.op)
      OP_UPDATE: begin
        if (!win_ok) restart_win(ms, us);
        el = ms - win_start;
        if (!(powered && duty_now != 0)) begin
          rpm_avg  = '0;
          stall_ok = 1'b0;
          if (el >= SAMPLE_MS) restart_win(ms, us);
        end else begin
          if (el >= SAMPLE_MS) begin
            meas   = ({32'd0, pulses} * 64'd60000) / ({32'd0, el} * 64'd2);
            pulses = '0;
            if (meas <= {48'd0, max_rpm}) begin
              if (rpm_avg == 0 || meas == 0) rpm_avg = meas[15:0];
              else rpm_avg = 16'((32'(rpm_avg) * 32'd3 + meas[31:0] + 32'd2) / 32'd4);
            end
            win_start = ms;
          end
          if (assist_on(ms) || rpm_avg >= MIN_OK_RPM) begin
            stall_ok = 1'b0;
          end else if (!stall_ok) begin
            stall_start = ms;
            stall_ok    = 1'b1;
          end else if (ms - stall_start >= GRACE_MS) begin
            failed = 1'b1;
          end
        end
      end
      OP_EDGE: begin
        if (us - last_edge >= {15'd0, edge_gap_us}) begin
          pulses    = pulses + 32'd1;
          last_edge = us;
          hit       = 1'b1;
        end
      end
      OP_SET: begin
        pct      = (it.speed_percent > 8'(MAX_PCT)) ? 8'(MAX_PCT) : it.speed_percent;
        duty_req = pct[6:0];
        if (pct == 0) begin
          duty_req   = '0;
          assist_end = '0;
          stall_ok   = 1'b0;
          failed     = 1'b0;
          rpm_avg    = '0;
          duty_now   = '0;
          powered    = 1'b0;
          restart_win(ms, us);
        end else if (!powered) begin
          assist_end = ms + ASSIST_MS;
          stall_ok   = 1'b0;
          failed     = 1'b0;
          restart_win(ms, us);
          duty_now   = MIN_RUN_PCT;
          powered    = 1'b1;
        end else if (assist_on(ms)) begin
          duty_now = MIN_RUN_PCT;
        end else begin
          duty_now = (pct[6:0] < MIN_RUN_PCT) ? MIN_RUN_PCT : pct[6:0];
        end
      end
      default: begin
      end
    endcase
    res.pwm_counts      = 8'(255 - (32'(duty_now) * 255 + 50) / 100);
    res.power_on        = powered;
    res.applied_percent = duty_now;
    res.speed_rpm       = rpm_avg;
    res.stall_failed    = failed;
    res.edge_accepted   = hit;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t res;
    if (!rst_n) begin
      max_rpm     = RESET_MAX_RPM;
      edge_gap_us = gap_for(RESET_MAX_RPM);
      powered     = 1'b0;
      duty_now    = '0;
      duty_req    = '0;
      rpm_avg     = '0;
      pulses      = '0;
      last_edge   = '0;
      win_start   = '0;
      win_ok      = 1'b0;
      assist_end  = '0;
      stall_start = '0;
      stall_ok    = 1'b0;
      failed      = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_rpm     = cfg_data;
        edge_gap_us = gap_for(cfg_data);
      end
      if (in_valid && in_ready) begin
        apply_event(in_item, res);
        status_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: status item with nothing expected, got %h", $time, out_item);
          errs++;
        end else begin
          want = status_q.pop_front();
          check_field("pwm_counts", want.pwm_counts, out_item.pwm_counts);
          check_field("power_on", want.power_on, out_item.power_on);
          check_field("applied_percent", want.applied_percent, out_item.applied_percent);
          check_field("speed_rpm", want.speed_rpm, out_item.speed_rpm);
          check_field("stall_failed", want.stall_failed, out_item.stall_failed);
          check_field("edge_accepted", want.edge_accepted, out_item.edge_accepted);
        end
      end
    end
    outstanding <= status_q.size();
  end

endmodule

[tb/tb_fan_tach_speed_supervisor_core.sv]
// Top of the fan tach speed supervisor testbench: clock, reset, directed and random event
// streams under several register settings and idling phases, and the final verdict.
// Depends on fts_pkg, fan_tach_speed_supervisor_core and fts_status_checker.
module tb_fan_tach_speed_supervisor_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fts_pkg::*;

  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          error_count;
  int          awaited_count;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned tach_gap = 5000;
  int unsigned edge_ms_span = 10;
  logic [31:0] cur_ms = 32'h0001_0000;
  logic [31:0] cur_us = '0;

  fan_tach_speed_supervisor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fts_status_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .awaited_count (awaited_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] ms,
                           input logic [31:0] us, input logic [7:0] pct);
    in_item_t it;
    it.op            = op;
    it.now_ms        = ms;
    it.now_us        = us;
    it.speed_percent = pct;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
  endtask

  function automatic logic [7:0] pick_pct();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      7:       return 8'($urandom_range(101, 255));
      8:       return 8'(MAX_PCT);
      9:       return 8'($urandom_range(1, 24));
      default: return 8'($urandom_range(1, 100));
    endcase
  endfunction

  task automatic play_random(input int unsigned target);
    int unsigned kind;
    int unsigned len;
    int unsigned r;
    int unsigned start;
    start = items_sent;
    while (items_sent - start < target) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        if ($urandom_range(2) == 0) push_item(OP_SET, cur_ms, cur_us, pick_pct());
        len = $urandom_range(8, 30);
        repeat (len) begin
          if ($urandom_range(9) < 7) begin
            r = $urandom_range(9);
            if (r < 7) cur_us += tach_gap + $urandom_range(0, tach_gap / 2);
            else if (r == 7) cur_us += tach_gap;
            else cur_us += tach_gap - $urandom_range(1, 20);
            cur_ms += $urandom_range(0, edge_ms_span);
            push_item(OP_EDGE, cur_ms, cur_us, 8'($urandom_range(255)));
          end else begin
            cur_ms += $urandom_range(0, 700);
            push_item(OP_UPDATE, cur_ms, cur_us, 8'($urandom_range(255)));
          end
        end
      end else if (kind <= 7) begin
        push_item(OP_SET, cur_ms, cur_us, pick_pct());
        len = $urandom_range(10, 14);
        repeat (len) begin
          cur_ms += $urandom_range(200, 1500);
          cur_us += $urandom_range(0, 100000);
          push_item(OP_UPDATE, cur_ms, cur_us, 8'($urandom_range(255)));
        end
      end else if (kind == 8) begin
        push_item(OP_SET, cur_ms, cur_us, 8'd0);
        cur_ms += $urandom_range(0, 2000);
        push_item(OP_UPDATE, cur_ms, cur_us, 8'($urandom_range(255)));
      end else begin
        push_item(2'($urandom_range(3)), $urandom, $urandom, 8'($urandom_range(255)));
        if ($urandom_range(1) == 0) begin
          cur_ms = $urandom;
          cur_us = $urandom;
        end
      end
    end
  endtask

  initial begin
    int unsigned cfg_vals[8];
    int unsigned v;
    int unsigned lim;
    cfg_vals = '{65535, 0, 300, 299, 6000, 1, 0, 0};
    cfg_vals[6] = $urandom_range(65535);
    cfg_vals[7] = $urandom_range(300, 3000);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_item(OP_UPDATE, 32'd100, 32'd1000, 8'd0);
    push_item(OP_IDLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    push_item(OP_EDGE, 32'd110, 32'd5999, 8'd0);
    push_item(OP_EDGE, 32'd120, 32'd6000, 8'd0);
    push_item(OP_SET, 32'd200, 32'd7000, 8'd255);
    push_item(OP_SET, 32'd300, 32'd7100, 8'd100);
    push_item(OP_UPDATE, 32'd1300, 32'd7200, 8'd0);
    push_item(OP_SET, 32'd5200, 32'd8000, 8'd1);
    push_item(OP_SET, 32'd5201, 32'd9000, 8'd100);
    push_item(OP_EDGE, 32'd5300, 32'd20000, 8'd0);
    push_item(OP_EDGE, 32'd5400, 32'd30000, 8'd0);
    push_item(OP_EDGE, 32'd5500, 32'd40000, 8'd0);
    push_item(OP_EDGE, 32'd5600, 32'd50000, 8'd0);
    push_item(OP_EDGE, 32'd5700, 32'd60000, 8'd0);
    push_item(OP_UPDATE, 32'd6300, 32'd70000, 8'd0);
    push_item(OP_UPDATE, 32'd9300, 32'd80000, 8'd0);
    push_item(OP_SET, 32'd9400, 32'd90000, 8'd0);
    push_item(OP_UPDATE, 32'd10500, 32'd95000, 8'd0);
    push_item(OP_SET, 32'hFFFF_F000, 32'h7FFF_FFFF, 8'd50);
    push_item(OP_UPDATE, 32'h0000_0100, 32'h8000_0000, 8'd0);
    push_item(OP_EDGE, 32'h0000_0200, 32'h0000_0000, 8'd0);
    push_item(OP_SET, 32'h0000_0300, 32'hFFFF_FFFF, 8'd128);
    push_item(OP_SET, 32'h0000_0400, 32'h0000_1000, 8'd0);

    for (int p = 0; p < 8; p++) begin
      drain();
      v = cfg_vals[p];
      cfg_valid <= 1'b1;
      cfg_data  <= 16'(v);
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      lim = (v < 300) ? 300 : v;
      tach_gap     = 60000000 / (2 * lim);
      edge_ms_span = 60000 / lim;
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 73;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 73;
        end
        default: begin
          idle_pct  = 7;
          stall_pct = 7;
        end
      endcase
      play_random(40);
    end

    drain();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
